@@ hw/rtl/box_mean_filter_5x5_top_assert.svh @@
// Assertion macros for the box mean filter top level.
// Depends on i_clk and i_rst_n being visible in the including scope.
`ifndef BOX_MEAN_FILTER_5X5_TOP_ASSERT_SVH
`define BOX_MEAN_FILTER_5X5_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define BMF_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define BMF_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/bmf_pkg.sv @@
// Shared constants, types and the reciprocal table of the box mean filter.
// No dependencies; imported by every RTL module of the block.
package bmf_pkg;

    localparam int KERNEL_SIZE = 5;
    localparam int RADIUS      = KERNEL_SIZE / 2;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;

    localparam int NCH     = 3;
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    localparam int PIX_W   = 8;
    localparam int DIM_W   = 12;
    localparam int CFG_IDX_W = 1;
    localparam int COL_AW  = $clog2(MAX_WIDTH);
    localparam int SLOT_W  = $clog2(KERNEL_SIZE);
    localparam int LINE_DEPTH = KERNEL_SIZE * MAX_WIDTH;
    localparam int LINE_AW = $clog2(LINE_DEPTH);
    localparam int COL_W   = $clog2(KERNEL_SIZE * 255 + 1);
    localparam int WIN_W   = $clog2(KERNEL_SIZE * KERNEL_SIZE * 255 + 1);
    localparam int SPAN_W  = $clog2(KERNEL_SIZE + 1);
    localparam int CNT_W   = $clog2(KERNEL_SIZE * KERNEL_SIZE + 1);
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W = RECIP_SHIFT + 1;
    localparam int PROD_W  = WIN_W + RECIP_W;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_reg_idx;

    typedef logic [NCH-1:0][PIX_W-1:0] t_pix3;
    typedef logic [NCH-1:0][COL_W-1:0] t_col3;
    typedef logic [NCH-1:0][WIN_W-1:0] t_win3;

    // Per-word control that travels down the pipeline
    typedef struct packed {
        logic [COL_AW-1:0] col;
        logic              first_row;
        logic              sub_old;
        logic              add_new;
        logic              upd;
        logic              first_col;
        logic              produce;
        logic              last;
        logic [SPAN_W-1:0] row_span;
        logic [SPAN_W-1:0] col_span;
    } t_item_ctl;

    // ceil(2^18 / n): floor(x * recip >> 18) equals floor(x / n) for x < 2^13
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        unique case (n)
            CNT_W'(2):  r = RECIP_W'(131072);
            CNT_W'(3):  r = RECIP_W'(87382);
            CNT_W'(4):  r = RECIP_W'(65536);
            CNT_W'(5):  r = RECIP_W'(52429);
            CNT_W'(6):  r = RECIP_W'(43691);
            CNT_W'(7):  r = RECIP_W'(37450);
            CNT_W'(8):  r = RECIP_W'(32768);
            CNT_W'(9):  r = RECIP_W'(29128);
            CNT_W'(10): r = RECIP_W'(26215);
            CNT_W'(11): r = RECIP_W'(23832);
            CNT_W'(12): r = RECIP_W'(21846);
            CNT_W'(13): r = RECIP_W'(20165);
            CNT_W'(14): r = RECIP_W'(18725);
            CNT_W'(15): r = RECIP_W'(17477);
            CNT_W'(16): r = RECIP_W'(16384);
            CNT_W'(17): r = RECIP_W'(15421);
            CNT_W'(18): r = RECIP_W'(14564);
            CNT_W'(19): r = RECIP_W'(13798);
            CNT_W'(20): r = RECIP_W'(13108);
            CNT_W'(21): r = RECIP_W'(12484);
            CNT_W'(22): r = RECIP_W'(11916);
            CNT_W'(23): r = RECIP_W'(11398);
            CNT_W'(24): r = RECIP_W'(10923);
            CNT_W'(25): r = RECIP_W'(10486);
            default:    r = RECIP_W'(262144);
        endcase
        return r;
    endfunction

endpackage

@@ hw/rtl/box_mean_filter_5x5_top.sv @@
// Box mean filter, 5x5 window, over 3-channel 8-bit pixels.
// Input words arrive in raster order over an extended scan of (height+2) rows
// by (width+2) columns; pixel fields outside the image are ignored. From scan
// position (2, 2) on, each input word yields one output word: the truncated
// mean of the clipped 5x5 window centered on image pixel (row-2, col-2), with
// last_pixel marking the bottom-right corner. Other positions yield nothing.
// Configuration: write width (index 0) or height (index 1) with i_cfg_we while
// idle; zero acts as one, values above 2048 as 2048, and a write restarts the
// scan. Both channels use valid/ready. A word passes stages one to three and
// its result the output register; one word per cycle is sustained while the
// receiver keeps up, set by the line store (one read-first access per word)
// and the column-sum memory (a read on accept and a write-back of the word
// before), each touched once per word. A stalled receiver fills the output
// register and then the three stages behind it; words with no result drain
// past a stall. Reset: 640x480, scan at (0, 0), pipeline empty; memories are
// not cleared, since every entry is written in a frame before it is read.
// Depends on bmf_pkg, bmf_scan, bmf_column, bmf_window.
`include "box_mean_filter_5x5_top_assert.svh"

module box_mean_filter_5x5_top import bmf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_pixel_valid,
    output logic                 o_pixel_ready,
    input  logic [PIX_W-1:0]     i_pixel_blue,
    input  logic [PIX_W-1:0]     i_pixel_green,
    input  logic [PIX_W-1:0]     i_pixel_red,
    output logic                 o_mean_valid,
    input  logic                 i_mean_ready,
    output logic [PIX_W-1:0]     o_mean_blue,
    output logic [PIX_W-1:0]     o_mean_green,
    output logic [PIX_W-1:0]     o_mean_red,
    output logic                 o_last_pixel
);

    logic      r_s1_v;
    logic      r_s2_v;
    logic      r_s3_v;
    logic      r_out_v;
    logic      r_out_last;
    t_item_ctl r_ctl1;
    t_item_ctl r_ctl2;
    t_item_ctl r_ctl3;

    logic               acc;
    logic               out_free;
    logic               out_load;
    logic               s1_adv;
    logic               s2_adv;
    logic               s3_adv;
    logic               s1_free;
    logic               s2_free;
    logic               s3_free;
    t_item_ctl          scan_ctl;
    logic [LINE_AW-1:0] line_addr;
    logic               line_we;
    t_pix3              in_pix;
    t_col3              col_sum;
    t_pix3              mean;
    logic               col_rmw;
    logic               col_clash;
    logic               span_ok;
    logic               corner_out;

    // Stage handshakes: at stage three, words without a result do not wait on the receiver
    always_comb begin
        out_free = !r_out_v || i_mean_ready;
        s3_adv   = r_s3_v && (!r_ctl3.produce || out_free);
        s3_free  = !r_s3_v || s3_adv;
        s2_adv   = r_s2_v && s3_free;
        s2_free  = !r_s2_v || s2_adv;
        s1_adv   = r_s1_v && s2_free;
        s1_free  = !r_s1_v || s1_adv;
        out_load = s3_adv && r_ctl3.produce;
    end

    assign o_pixel_ready = s1_free;
    assign acc           = i_pixel_valid && s1_free;

    always_comb begin
        in_pix[CH_BLUE]  = i_pixel_blue;
        in_pix[CH_GREEN] = i_pixel_green;
        in_pix[CH_RED]   = i_pixel_red;
    end

    bmf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_acc       (acc),
        .o_ctl       (scan_ctl),
        .o_line_addr (line_addr),
        .o_line_we   (line_we)
    );

    bmf_column u_column (
        .i_clk       (i_clk),
        .i_acc       (acc),
        .i_line_we   (line_we),
        .i_line_addr (line_addr),
        .i_pix       (in_pix),
        .i_ctl       (scan_ctl),
        .i_s1_adv    (s1_adv),
        .i_ctl1      (r_ctl1),
        .o_col_sum   (col_sum)
    );

    bmf_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_adv    (s1_adv),
        .i_ctl1      (r_ctl1),
        .i_s2_adv    (s2_adv),
        .i_first_col (r_ctl2.first_col),
        .i_col_sum   (col_sum),
        .i_out_load  (out_load),
        .o_mean      (mean)
    );

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_v <= acc;
            end
            if (s2_free) begin
                r_s2_v <= s1_adv;
            end
            if (s3_free) begin
                r_s3_v <= s2_adv;
            end
            if (out_free) begin
                r_out_v <= out_load;
            end
        end
    end

    // Carry the control word along with its data
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ctl1 <= scan_ctl;
        end
        if (s1_adv) begin
            r_ctl2 <= r_ctl1;
        end
        if (s2_adv) begin
            r_ctl3 <= r_ctl2;
        end
        if (out_load) begin
            r_out_last <= r_ctl3.last;
        end
    end

    assign o_mean_valid = r_out_v;
    assign o_mean_blue  = mean[CH_BLUE];
    assign o_mean_green = mean[CH_GREEN];
    assign o_mean_red   = mean[CH_RED];
    assign o_last_pixel = r_out_last;

    // Terms for the checks below
    assign col_rmw    = acc && s1_adv && r_ctl1.upd;
    assign col_clash  = (scan_ctl.col == r_ctl1.col);
    assign span_ok    = (r_ctl1.row_span >= SPAN_W'(1))
                     && (r_ctl1.row_span <= SPAN_W'(KERNEL_SIZE))
                     && (r_ctl1.col_span >= SPAN_W'(1))
                     && (r_ctl1.col_span <= SPAN_W'(KERNEL_SIZE));
    assign corner_out = out_load && r_ctl3.last;

    `BMF_ASSERT_IMP(a_col_sum_no_overlap, col_rmw, !col_clash, "column-sum read meets write")
    `BMF_ASSERT_IMP(a_span_range, r_s1_v, span_ok, "window span out of range")
    `BMF_ASSERT_NXT(a_last_delivered, corner_out, o_mean_valid && o_last_pixel, "last flag lost")

endmodule

@@ hw/rtl/bmf_scan.sv @@
// Configuration registers and scan position of the box mean filter.
// Depends on bmf_pkg; produces per-word control and line store addressing.
module bmf_scan import bmf_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  logic                 i_acc,
    output t_item_ctl            o_ctl,
    output logic [LINE_AW-1:0]   o_line_addr,
    output logic                 o_line_we
);

    logic [DIM_W-1:0]  r_width;
    logic [DIM_W-1:0]  r_height;
    logic [DIM_W-1:0]  r_row;
    logic [DIM_W-1:0]  r_col;
    logic [SLOT_W-1:0] r_slot;

    logic [DIM_W-1:0] row_end;
    logic [DIM_W-1:0] col_end;
    logic [DIM_W-1:0] row_hi;
    logic [DIM_W-1:0] row_lo;
    logic [DIM_W-1:0] col_hi;
    logic [DIM_W-1:0] col_lo;
    logic [DIM_W-1:0] row_diff;
    logic [DIM_W-1:0] col_diff;

    // Zero acts as one, oversize acts as the maximum
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // Hold dimensions; any write restarts the scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= clamp_dim(i_cfg_data, DIM_W'(MAX_WIDTH));
                REG_IMAGE_HEIGHT: r_height <= clamp_dim(i_cfg_data, DIM_W'(MAX_HEIGHT));
            endcase
        end
    end

    assign row_end = r_height + DIM_W'(RADIUS - 1);
    assign col_end = r_width + DIM_W'(RADIUS - 1);

    // Advance the scan over the extended frame, wrap at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_row  <= '0;
            r_col  <= '0;
            r_slot <= '0;
        end else if (i_acc) begin
            if (r_col == col_end) begin
                r_col <= '0;
                if (r_row == row_end) begin
                    r_row  <= '0;
                    r_slot <= '0;
                end else begin
                    r_row  <= r_row + DIM_W'(1);
                    r_slot <= (r_slot == SLOT_W'(KERNEL_SIZE - 1)) ? '0
                                                                  : r_slot + SLOT_W'(1);
                end
            end else begin
                r_col <= r_col + DIM_W'(1);
            end
        end
    end

    // Clipped window extent in rows and columns
    always_comb begin
        row_hi = (r_row < r_height) ? r_row : r_height - DIM_W'(1);
        row_lo = (r_row >= DIM_W'(KERNEL_SIZE - 1)) ? r_row - DIM_W'(KERNEL_SIZE - 1) : '0;
        col_hi = (r_col < r_width) ? r_col : r_width - DIM_W'(1);
        col_lo = (r_col >= DIM_W'(KERNEL_SIZE - 1)) ? r_col - DIM_W'(KERNEL_SIZE - 1) : '0;
        row_diff = row_hi - row_lo;
        col_diff = col_hi - col_lo;
    end

    always_comb begin
        o_ctl.col       = r_col[COL_AW-1:0];
        o_ctl.first_row = (r_row == '0);
        o_ctl.sub_old   = (r_row >= DIM_W'(KERNEL_SIZE));
        o_ctl.add_new   = (r_row < r_height);
        o_ctl.upd       = (r_col < r_width);
        o_ctl.first_col = (r_col == '0);
        o_ctl.produce   = (r_row >= DIM_W'(RADIUS)) && (r_col >= DIM_W'(RADIUS));
        o_ctl.last      = (r_row == row_end) && (r_col == col_end);
        o_ctl.row_span  = row_diff[SPAN_W-1:0] + SPAN_W'(1);
        o_ctl.col_span  = col_diff[SPAN_W-1:0] + SPAN_W'(1);
    end

    assign o_line_addr = {r_slot, r_col[COL_AW-1:0]};
    assign o_line_we   = i_acc && o_ctl.add_new && o_ctl.upd;

endmodule

@@ hw/rtl/bmf_column.sv @@
// Line store and column-sum memory with their read-modify-write update.
// Depends on bmf_pkg; fed by bmf_scan control, feeds bmf_window.
module bmf_column import bmf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_acc,
    input  logic               i_line_we,
    input  logic [LINE_AW-1:0] i_line_addr,
    input  t_pix3              i_pix,
    input  t_item_ctl          i_ctl,
    input  logic               i_s1_adv,
    input  t_item_ctl          i_ctl1,
    output t_col3              o_col_sum
);

    t_pix3 line_mem [LINE_DEPTH];
    t_col3 col_mem  [MAX_WIDTH];

    t_pix3 r_line_rd;
    t_col3 r_col_rd;
    t_pix3 r_s1_pix;
    t_col3 r_s2_sum;
    t_col3 n_col_sum;

    // Read-first line store: fetch the pixel five rows up, then overwrite it
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_line_rd <= line_mem[i_line_addr];
            r_s1_pix  <= i_pix;
        end
        if (i_line_we) begin
            line_mem[i_line_addr] <= i_pix;
        end
    end

    // Column sums: read on accept, write back when the word leaves stage one.
    // The same column comes back only after width+2 words, so no overlap.
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_col_rd <= col_mem[i_ctl.col];
        end
        if (i_s1_adv && i_ctl1.upd) begin
            col_mem[i_ctl1.col] <= n_col_sum;
        end
    end

    // Slide the vertical window: add the new row, drop the row five up
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            n_col_sum[ch] = (i_ctl1.first_row ? '0 : r_col_rd[ch])
                          + (i_ctl1.add_new ? COL_W'(r_s1_pix[ch]) : '0)
                          - (i_ctl1.sub_old ? COL_W'(r_line_rd[ch]) : '0);
        end
    end

    // Columns outside the image contribute nothing
    always_ff @(posedge i_clk) begin
        if (i_s1_adv) begin
            r_s2_sum <= i_ctl1.upd ? n_col_sum : '0;
        end
    end

    assign o_col_sum = r_s2_sum;

endmodule

@@ hw/rtl/bmf_window.sv @@
// Horizontal window sum, reciprocal scaling and result register.
// Depends on bmf_pkg; takes column sums from bmf_column.
module bmf_window import bmf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s1_adv,
    input  t_item_ctl i_ctl1,
    input  logic      i_s2_adv,
    input  logic      i_first_col,
    input  t_col3     i_col_sum,
    input  logic      i_out_load,
    output t_pix3     o_mean
);

    t_col3              r_win [KERNEL_SIZE-1];
    logic [RECIP_W-1:0] r_s2_recip;
    logic [RECIP_W-1:0] r_s3_recip;
    t_win3              r_s3_sum;
    t_pix3              r_mean;

    logic [2*SPAN_W-1:0] area;
    t_win3               n_sum;
    logic [PROD_W-1:0]   prod [NCH];

    // Window area and its reciprocal
    assign area = (2*SPAN_W)'(i_ctl1.row_span) * (2*SPAN_W)'(i_ctl1.col_span);

    always_ff @(posedge i_clk) begin
        if (i_s1_adv) begin
            r_s2_recip <= recip_of(area[CNT_W-1:0]);
        end
    end

    // Sum the current column with the previous ones of this row
    always_comb begin
        logic [WIN_W-1:0] acc;
        for (int ch = 0; ch < NCH; ch++) begin
            acc = WIN_W'(i_col_sum[ch]);
            if (!i_first_col) begin
                for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                    acc = acc + WIN_W'(r_win[j][ch]);
                end
            end
            n_sum[ch] = acc;
        end
    end

    // Shift the column window; a new row starts from empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < KERNEL_SIZE - 1; j++) begin
                r_win[j] <= '0;
            end
        end else if (i_s2_adv) begin
            r_win[0] <= i_col_sum;
            for (int j = 1; j < KERNEL_SIZE - 1; j++) begin
                r_win[j] <= i_first_col ? '0 : r_win[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s2_adv) begin
            r_s3_sum   <= n_sum;
            r_s3_recip <= r_s2_recip;
        end
    end

    // Divide by the area through the reciprocal
    always_comb begin
        for (int ch = 0; ch < NCH; ch++) begin
            prod[ch] = PROD_W'(r_s3_sum[ch]) * PROD_W'(r_s3_recip);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_load) begin
            for (int ch = 0; ch < NCH; ch++) begin
                r_mean[ch] <= prod[ch][RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
            end
        end
    end

    assign o_mean = r_mean;

endmodule
